>>> hw/rtl/jpeg_header_marker_parser_top_macros.svh
// Assertion macros for the JPEG header marker parser.
// Used by jpeg_header_marker_parser_top; expects clk and arst_n in scope.
`ifndef JPEG_HEADER_MARKER_PARSER_TOP_MACROS_SVH
`define JPEG_HEADER_MARKER_PARSER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define JHMP_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define JHMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define JHMP_ASSERT(lbl, cond)
`define JHMP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/jhmp_pkg.sv
// Types and codes of the JPEG header marker parser.
// No dependencies.
`default_nettype none
package jhmp_pkg;
	typedef enum logic [26:0] {
		PH_START    = 27'h0000001, PH_FILL     = 27'h0000002,
		PH_LEN_HI   = 27'h0000004, PH_LEN_LO   = 27'h0000008,
		PH_SOF_PREC = 27'h0000010, PH_SOF_H_HI = 27'h0000020,
		PH_SOF_H_LO = 27'h0000040, PH_SOF_W_HI = 27'h0000080,
		PH_SOF_W_LO = 27'h0000100, PH_SOF_NC   = 27'h0000200,
		PH_SOF_ID   = 27'h0000400, PH_SOF_SAMP = 27'h0000800,
		PH_SOF_QSEL = 27'h0001000, PH_DQT_IDX  = 27'h0002000,
		PH_DQT_ENT  = 27'h0004000, PH_DHT_IDX  = 27'h0008000,
		PH_DHT_CNT  = 27'h0010000, PH_DHT_VAL  = 27'h0020000,
		PH_DRI_HI   = 27'h0040000, PH_DRI_LO   = 27'h0080000,
		PH_SOS_NC   = 27'h0100000, PH_SOS_SEL  = 27'h0200000,
		PH_SOS_TBL  = 27'h0400000, PH_SOS_SKIP = 27'h0800000,
		PH_SCAN     = 27'h1000000, PH_SKIP     = 27'h2000000,
		PH_DEAD     = 27'h4000000
	} phase_t;

	localparam logic [4:0] K_HEIGHT = 5'd0, K_WIDTH = 5'd1, K_COMP_CNT = 5'd2,
		K_COMP_ID = 5'd3, K_SAMPLING = 5'd4, K_QSEL = 5'd5, K_QENTRY = 5'd6,
		K_DC_CNT = 5'd7, K_DC_VAL = 5'd8, K_AC_CNT = 5'd9, K_AC_VAL = 5'd10,
		K_RESTART = 5'd11, K_SCAN_CNT = 5'd12, K_SCAN_SEL = 5'd13,
		K_SCAN_TBL = 5'd14, K_HDR_DONE = 5'd15, K_SCAN_LEN = 5'd16, K_ERROR = 5'd17;

	localparam logic [2:0] E_NONE = 3'd0, E_NO_FF = 3'd1, E_SIZE = 3'd2,
		E_QIDX = 3'd3, E_HIDX = 3'd4, E_HBIG = 3'd5, E_OVERRUN = 3'd6;

	localparam logic [7:0] M_FF = 8'hFF, M_SOI = 8'hD8, M_SOF0 = 8'hC0,
		M_DQT = 8'hDB, M_DHT = 8'hC4, M_DRI = 8'hDD, M_SOS = 8'hDA;

	localparam logic [1:0] CFG_WIDTH = 2'd0, CFG_HEIGHT = 2'd1;

	localparam logic [7:0] QUANT_ENTRIES = 8'd64;
	localparam logic [7:0] MAX_HUFF_VALUES = 8'd162;
	localparam logic [7:0] DC_MAX_VALUES = 8'd12;

	typedef struct packed {
		logic [4:0]  kind;
		logic [1:0]  tbl;
		logic [7:0]  ent;
		logic [23:0] val;
		logic [2:0]  err;
		logic [3:0]  mh;
		logic [3:0]  mv;
		logic        hs;
		logic        last;
	} rec_t;
endpackage
`default_nettype wire

>>> hw/rtl/jpeg_header_marker_parser_top.sv
// JPEG baseline header marker parser, one byte a beat in, records out.
// Depends on jhmp_pkg and jpeg_header_marker_parser_top_macros.svh.
//
// channel | handshake            | payload
// in      | in_valid / in_stall  | data_byte, final_byte
// out     | out_valid / out_stall| record_kind .. last_of_run
// cfg     | cfg_we               | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low: the parse state updates in the cycle the beat is taken.
// Each byte yields 0 to 2 records into a 4-entry result queue; in_stall rises
// while fewer than two slots are free, so the queue sets the throughput.
// arst_n clears parse state and queue and sets the size registers to 640 x 480.
`default_nettype none
`include "jpeg_header_marker_parser_top_macros.svh"
module jpeg_header_marker_parser_top
	import jhmp_pkg::*;
#(
	parameter int SCAN_COUNT_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       record_kind,
	output logic [1:0]       table_index,
	output logic [7:0]       entry_index,
	output logic [23:0]      field_value,
	output logic [2:0]       error_code,
	output logic [3:0]       max_h_sampling,
	output logic [3:0]       max_v_sampling,
	output logic             huffman_seen,
	output logic             last_of_run
);
	localparam logic [SCAN_COUNT_BITS-1:0] SCAN_MAX = '1;

	logic [15:0] exp_w_q, exp_h_q;
	phase_t      phase_q, phase_n;
	logic [7:0]  marker_q, marker_n, fhb_q, fhb_n, ic_q, ic_n, it_q, it_n, hvt_q, hvt_n;
	logic [15:0] seg_q, seg_n;
	logic [1:0]  ct_q, ct_n;
	logic        dc_q, dc_n, hs_q, hs_n;
	logic [3:0]  mh_q, mh_n, mv_q, mv_n;
	logic [SCAN_COUNT_BITS-1:0] scan_q, scan_n;

	rec_t        res [2];
	logic [1:0]  n_res;
	rec_t        fifo_q [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;
	logic        in_acc, out_pop;

	function automatic rec_t mk(logic [4:0] k, logic [1:0] t, logic [7:0] e,
		logic [23:0] v, logic [2:0] er, logic [3:0] h, logic [3:0] vv, logic s);
		rec_t r;
		r.kind = k; r.tbl = t; r.ent = e; r.val = v; r.err = er;
		r.mh = h; r.mv = vv; r.hs = s; r.last = 1'b0;
		return r;
	endfunction

	assign in_stall  = cnt_q > 3'd2;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = cnt_q != 3'd0;
	assign out_pop   = out_valid && !out_stall;

	always_comb begin
		logic [15:0] v16;
		logic [8:0]  sum;
		logic [31:0] cext;
		rec_t        rec;
		logic        do_emit, do_fail;
		logic [2:0]  fcode;
		phase_n = phase_q; marker_n = marker_q; seg_n = seg_q; fhb_n = fhb_q;
		ic_n = ic_q; it_n = it_q; ct_n = ct_q; dc_n = dc_q; hvt_n = hvt_q;
		mh_n = mh_q; mv_n = mv_q; hs_n = hs_q; scan_n = scan_q;
		res[0] = '0; res[1] = '0; n_res = 2'd0;
		rec = '0; do_emit = 1'b0; do_fail = 1'b0; fcode = E_NONE;
		v16 = {fhb_q, data_byte};
		sum = 9'(hvt_q) + 9'(data_byte);
		cext = 32'(scan_q);
		unique case (phase_q)
			PH_START: begin
				if (data_byte != M_FF) begin do_fail = 1'b1; fcode = E_NO_FF; end
				else phase_n = PH_FILL;
			end
			PH_FILL: begin
				if (data_byte == M_SOI) phase_n = PH_START;
				else if (data_byte != M_FF) begin
					marker_n = data_byte; phase_n = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin fhb_n = data_byte; phase_n = PH_LEN_LO; end
			PH_LEN_LO: begin
				seg_n = (v16 >= 16'd2) ? v16 - 16'd2 : 16'd0;
				if (marker_q == M_SOF0) phase_n = PH_SOF_PREC;
				else if (marker_q == M_DQT)
					phase_n = (seg_n != 16'd0) ? PH_DQT_IDX : PH_START;
				else if (marker_q == M_DHT) begin
					hs_n = 1'b1;
					phase_n = (seg_n != 16'd0) ? PH_DHT_IDX : PH_START;
				end else if (marker_q == M_DRI) phase_n = PH_DRI_HI;
				else if (marker_q == M_SOS) phase_n = PH_SOS_NC;
				else phase_n = (seg_n != 16'd0) ? PH_SKIP : PH_START;
			end
			PH_SOF_PREC: phase_n = PH_SOF_H_HI;
			PH_SOF_H_HI: begin fhb_n = data_byte; phase_n = PH_SOF_H_LO; end
			PH_SOF_H_LO: begin
				do_emit = 1'b1; rec = mk(K_HEIGHT, 2'd0, 8'd0, 24'(v16), E_NONE, mh_n, mv_n, hs_n);
				it_n = (v16 != exp_h_q) ? 8'd1 : 8'd0;
				phase_n = PH_SOF_W_HI;
			end
			PH_SOF_W_HI: begin fhb_n = data_byte; phase_n = PH_SOF_W_LO; end
			PH_SOF_W_LO: begin
				do_emit = 1'b1; rec = mk(K_WIDTH, 2'd0, 8'd0, 24'(v16), E_NONE, mh_n, mv_n, hs_n);
				if (it_q != 8'd0 || v16 != exp_w_q) begin do_fail = 1'b1; fcode = E_SIZE; end
				else phase_n = PH_SOF_NC;
			end
			PH_SOF_NC: begin
				do_emit = 1'b1;
				rec = mk(K_COMP_CNT, 2'd0, 8'd0, 24'(data_byte), E_NONE, mh_n, mv_n, hs_n);
				it_n = data_byte; ic_n = 8'd0;
				phase_n = (data_byte != 8'd0) ? PH_SOF_ID : PH_START;
			end
			PH_SOF_ID: begin
				do_emit = 1'b1;
				rec = mk(K_COMP_ID, 2'd0, ic_q, 24'(data_byte), E_NONE, mh_n, mv_n, hs_n);
				phase_n = PH_SOF_SAMP;
			end
			PH_SOF_SAMP: begin
				if (data_byte[7:4] > mh_q) mh_n = data_byte[7:4];
				if (data_byte[3:0] > mv_q) mv_n = data_byte[3:0];
				do_emit = 1'b1;
				rec = mk(K_SAMPLING, 2'd0, ic_q, 24'(data_byte), E_NONE, mh_n, mv_n, hs_n);
				phase_n = PH_SOF_QSEL;
			end
			PH_SOF_QSEL: begin
				do_emit = 1'b1;
				rec = mk(K_QSEL, 2'd0, ic_q, 24'(data_byte), E_NONE, mh_n, mv_n, hs_n);
				ic_n = ic_q + 8'd1;
				phase_n = (ic_n == it_q) ? PH_START : PH_SOF_ID;
			end
			PH_DQT_IDX: begin
				seg_n = (seg_q != 16'd0) ? seg_q - 16'd1 : 16'd0;
				if (data_byte >= 8'd4) begin do_fail = 1'b1; fcode = E_QIDX; end
				else begin
					ct_n = data_byte[1:0]; ic_n = 8'd0;
					if (seg_n == 16'd0) begin do_fail = 1'b1; fcode = E_OVERRUN; end
					else phase_n = PH_DQT_ENT;
				end
			end
			PH_DQT_ENT: begin
				seg_n = (seg_q != 16'd0) ? seg_q - 16'd1 : 16'd0;
				do_emit = 1'b1;
				rec = mk(K_QENTRY, ct_q, ic_q, 24'(data_byte), E_NONE, mh_n, mv_n, hs_n);
				ic_n = ic_q + 8'd1;
				if (ic_n >= QUANT_ENTRIES)
					phase_n = (seg_n != 16'd0) ? PH_DQT_IDX : PH_START;
				else if (seg_n == 16'd0) begin do_fail = 1'b1; fcode = E_OVERRUN; end
			end
			PH_DHT_IDX: begin
				seg_n = (seg_q != 16'd0) ? seg_q - 16'd1 : 16'd0;
				if (data_byte[3:0] >= 4'd2) begin do_fail = 1'b1; fcode = E_HIDX; end
				else begin
					dc_n = data_byte[7:4] == 4'd0;
					ct_n = data_byte[1:0]; ic_n = 8'd0; hvt_n = 8'd0;
					if (seg_n == 16'd0) begin do_fail = 1'b1; fcode = E_OVERRUN; end
					else phase_n = PH_DHT_CNT;
				end
			end
			PH_DHT_CNT: begin
				seg_n = (seg_q != 16'd0) ? seg_q - 16'd1 : 16'd0;
				do_emit = 1'b1;
				rec = mk(dc_q ? K_DC_CNT : K_AC_CNT, ct_q, ic_q, 24'(data_byte), E_NONE,
					mh_n, mv_n, hs_n);
				hvt_n = sum[8] ? 8'hFF : sum[7:0];
				ic_n = ic_q + 8'd1;
				if (ic_n >= 8'd16) begin
					if ((dc_q && hvt_n > DC_MAX_VALUES) || hvt_n > MAX_HUFF_VALUES) begin
						do_fail = 1'b1; fcode = E_HBIG;
					end else if (hvt_n == 8'd0)
						phase_n = (seg_n != 16'd0) ? PH_DHT_IDX : PH_START;
					else if (seg_n == 16'd0) begin do_fail = 1'b1; fcode = E_OVERRUN; end
					else begin ic_n = 8'd0; phase_n = PH_DHT_VAL; end
				end else if (seg_n == 16'd0) begin do_fail = 1'b1; fcode = E_OVERRUN; end
			end
			PH_DHT_VAL: begin
				seg_n = (seg_q != 16'd0) ? seg_q - 16'd1 : 16'd0;
				do_emit = 1'b1;
				rec = mk(dc_q ? K_DC_VAL : K_AC_VAL, ct_q, ic_q, 24'(data_byte), E_NONE,
					mh_n, mv_n, hs_n);
				ic_n = ic_q + 8'd1;
				if (ic_n >= hvt_q) phase_n = (seg_n != 16'd0) ? PH_DHT_IDX : PH_START;
				else if (seg_n == 16'd0) begin do_fail = 1'b1; fcode = E_OVERRUN; end
			end
			PH_DRI_HI: begin fhb_n = data_byte; phase_n = PH_DRI_LO; end
			PH_DRI_LO: begin
				do_emit = 1'b1; rec = mk(K_RESTART, 2'd0, 8'd0, 24'(v16), E_NONE, mh_n, mv_n, hs_n);
				phase_n = PH_START;
			end
			PH_SOS_NC: begin
				do_emit = 1'b1;
				rec = mk(K_SCAN_CNT, 2'd0, 8'd0, 24'(data_byte), E_NONE, mh_n, mv_n, hs_n);
				it_n = data_byte; ic_n = 8'd0;
				phase_n = (data_byte != 8'd0) ? PH_SOS_SEL : PH_SOS_SKIP;
			end
			PH_SOS_SEL: begin
				do_emit = 1'b1;
				rec = mk(K_SCAN_SEL, 2'd0, ic_q, 24'(data_byte), E_NONE, mh_n, mv_n, hs_n);
				phase_n = PH_SOS_TBL;
			end
			PH_SOS_TBL: begin
				do_emit = 1'b1;
				rec = mk(K_SCAN_TBL, 2'd0, ic_q, 24'(data_byte), E_NONE, mh_n, mv_n, hs_n);
				ic_n = ic_q + 8'd1;
				if (ic_n == it_q) begin ic_n = 8'd0; phase_n = PH_SOS_SKIP; end
				else phase_n = PH_SOS_SEL;
			end
			PH_SOS_SKIP: begin
				ic_n = ic_q + 8'd1;
				if (ic_n >= 8'd3) begin
					do_emit = 1'b1;
					rec = mk(K_HDR_DONE, 2'd0, 8'd0, 24'd0, E_NONE, mh_n, mv_n, hs_n);
					scan_n = '0; phase_n = PH_SCAN;
				end
			end
			PH_SCAN: if (scan_q != SCAN_MAX) scan_n = scan_q + 1'b1;
			PH_SKIP: begin
				seg_n = (seg_q != 16'd0) ? seg_q - 16'd1 : 16'd0;
				if (seg_n == 16'd0) phase_n = PH_START;
			end
			PH_DEAD: phase_n = PH_DEAD;
			default: phase_n = PH_DEAD;
		endcase
		if (do_emit) begin res[0] = rec; n_res = 2'd1; end
		if (do_fail) begin
			res[n_res[0]] = mk(K_ERROR, 2'd0, 8'd0, 24'd0, fcode, mh_n, mv_n, hs_n);
			n_res = n_res + 2'd1;
			phase_n = PH_DEAD;
		end
		if (final_byte) begin
			cext = 32'(scan_n);
			if (phase_n == PH_SCAN) begin
				res[n_res[0]] = mk(K_SCAN_LEN, 2'd0, 8'd0,
					(cext > 32'hFFFFFF) ? 24'hFFFFFF : cext[23:0], E_NONE, mh_n, mv_n, hs_n);
				n_res = n_res + 2'd1;
			end else if (phase_n != PH_DEAD) begin
				res[n_res[0]] = mk(K_ERROR, 2'd0, 8'd0, 24'd0, E_OVERRUN, mh_n, mv_n, hs_n);
				n_res = n_res + 2'd1;
			end
			phase_n = PH_START; marker_n = '0; seg_n = '0; fhb_n = '0; ic_n = '0;
			it_n = '0; ct_n = '0; dc_n = 1'b0; hvt_n = '0; mh_n = '0; mv_n = '0;
			hs_n = 1'b0; scan_n = '0;
		end
		if (n_res == 2'd1) res[0].last = 1'b1;
		if (n_res == 2'd2) res[1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_w_q <= 16'd640; exp_h_q <= 16'd480;
			phase_q <= PH_START; marker_q <= '0; seg_q <= '0; fhb_q <= '0; ic_q <= '0;
			it_q <= '0; ct_q <= '0; dc_q <= 1'b0; hvt_q <= '0; mh_q <= '0; mv_q <= '0;
			hs_q <= 1'b0; scan_q <= '0;
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_WIDTH) exp_w_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_HEIGHT) exp_h_q <= cfg_data;
			if (in_acc) begin
				phase_q <= phase_n; marker_q <= marker_n; seg_q <= seg_n; fhb_q <= fhb_n;
				ic_q <= ic_n; it_q <= it_n; ct_q <= ct_n; dc_q <= dc_n; hvt_q <= hvt_n;
				mh_q <= mh_n; mv_q <= mv_n; hs_q <= hs_n; scan_q <= scan_n;
				wp_q <= wp_q + n_res;
			end
			if (out_pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + (in_acc ? 3'(n_res) : 3'd0) - (out_pop ? 3'd1 : 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && n_res != 2'd0) fifo_q[wp_q] <= res[0];
		if (in_acc && n_res == 2'd2) fifo_q[wp_q + 2'd1] <= res[1];
	end

	assign record_kind    = fifo_q[rp_q].kind;
	assign table_index    = fifo_q[rp_q].tbl;
	assign entry_index    = fifo_q[rp_q].ent;
	assign field_value    = fifo_q[rp_q].val;
	assign error_code     = fifo_q[rp_q].err;
	assign max_h_sampling = fifo_q[rp_q].mh;
	assign max_v_sampling = fifo_q[rp_q].mv;
	assign huffman_seen   = fifo_q[rp_q].hs;
	assign last_of_run    = fifo_q[rp_q].last;

	`JHMP_ASSERT(a_cnt_bound, cnt_q <= 3'd4)
	`JHMP_ASSERT_NEXT(a_final_clears, in_acc && final_byte, phase_q == PH_START && scan_q == '0)
	`JHMP_ASSERT(a_dead_quiet, !(phase_q == PH_DEAD && in_acc && !final_byte) || n_res == 2'd0)
	`JHMP_ASSERT_NEXT(a_idle_hold, !in_acc && !out_pop, cnt_q == $past(cnt_q))
endmodule
`default_nettype wire

>>> sim/tb_jpeg_header_marker_parser_top.sv
// Testbench for jpeg_header_marker_parser_top: JPEG frames are streamed one byte
// a beat; an in-bench parser predicts every record. Depends on jhmp_pkg and the RTL.
`timescale 1ns / 100ps
module tb_jpeg_header_marker_parser_top;
	import jhmp_pkg::*;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_stall;
	logic [7:0] data_byte;
	logic final_byte;
	logic out_valid, out_stall;
	logic [4:0] record_kind;
	logic [1:0] table_index;
	logic [7:0] entry_index;
	logic [23:0] field_value;
	logic [2:0] error_code;
	logic [3:0] max_h_sampling, max_v_sampling;
	logic huffman_seen, last_of_run;

	jpeg_header_marker_parser_top DUT (.*);

	// predictor state
	phase_t ph;
	logic [7:0] mk, hib, cnt, tot, hvt;
	logic [15:0] segrem;
	logic [1:0] curtbl;
	logic isdc, hseen;
	logic [3:0] mxh, mxv;
	logic [23:0] scancnt;
	logic [15:0] exp_w, exp_h;
	int nres;

	rec_t pending_recs[$];
	int mismatches, cycles;
	bit txn_busy;
	int burst_left;
	byte unsigned frame[$];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("tb_jpeg_header_marker_parser_top: done, errors");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		case (cycles / 700 % 3)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 6);
		endcase
	end

	always @(posedge clk) begin
		rec_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{record_kind, table_index, entry_index, field_value, error_code,
				max_h_sampling, max_v_sampling, huffman_seen, last_of_run};
			if (pending_recs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected record %p", got);
			end else begin
				want = pending_recs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
				end
			end
		end
	end

	function automatic void clear_frame();
		ph = PH_START; mk = 0; segrem = 0; hib = 0; cnt = 0; tot = 0; curtbl = 0;
		isdc = 0; hvt = 0; mxh = 0; mxv = 0; hseen = 0; scancnt = 0;
	endfunction

	function automatic void push_rec(logic [4:0] k, logic [1:0] t, logic [7:0] e,
			logic [23:0] v, logic [2:0] er);
		if (nres < 2) begin
			pending_recs.push_back('{k, t, e, v, er, mxh, mxv, hseen, 1'b0});
			nres++;
		end
	endfunction

	function automatic void abort_frame(logic [2:0] er);
		push_rec(K_ERROR, 0, 0, 0, er);
		ph = PH_DEAD;
	endfunction

	function automatic void take_seg();
		if (segrem != 0) segrem--;
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic fin);
		logic [15:0] v;
		int s;
		nres = 0;
		case (ph)
			PH_START: if (b != M_FF) abort_frame(E_NO_FF); else ph = PH_FILL;
			PH_FILL: if (b == M_SOI) ph = PH_START;
				else if (b != M_FF) begin mk = b; ph = PH_LEN_HI; end
			PH_LEN_HI: begin hib = b; ph = PH_LEN_LO; end
			PH_LEN_LO: begin
				v = {hib, b};
				segrem = v >= 2 ? v - 16'd2 : 16'd0;
				if (mk == M_SOF0) ph = PH_SOF_PREC;
				else if (mk == M_DQT) ph = segrem != 0 ? PH_DQT_IDX : PH_START;
				else if (mk == M_DHT) begin
					hseen = 1;
					ph = segrem != 0 ? PH_DHT_IDX : PH_START;
				end else if (mk == M_DRI) ph = PH_DRI_HI;
				else if (mk == M_SOS) ph = PH_SOS_NC;
				else ph = segrem != 0 ? PH_SKIP : PH_START;
			end
			PH_SOF_PREC: ph = PH_SOF_H_HI;
			PH_SOF_H_HI: begin hib = b; ph = PH_SOF_H_LO; end
			PH_SOF_H_LO: begin
				v = {hib, b};
				push_rec(K_HEIGHT, 0, 0, v, 0);
				tot = (v != exp_h);
				ph = PH_SOF_W_HI;
			end
			PH_SOF_W_HI: begin hib = b; ph = PH_SOF_W_LO; end
			PH_SOF_W_LO: begin
				v = {hib, b};
				push_rec(K_WIDTH, 0, 0, v, 0);
				if (tot != 0 || v != exp_w) abort_frame(E_SIZE); else ph = PH_SOF_NC;
			end
			PH_SOF_NC: begin
				push_rec(K_COMP_CNT, 0, 0, b, 0);
				tot = b; cnt = 0;
				ph = b != 0 ? PH_SOF_ID : PH_START;
			end
			PH_SOF_ID: begin push_rec(K_COMP_ID, 0, cnt, b, 0); ph = PH_SOF_SAMP; end
			PH_SOF_SAMP: begin
				if (b[7:4] > mxh) mxh = b[7:4];
				if (b[3:0] > mxv) mxv = b[3:0];
				push_rec(K_SAMPLING, 0, cnt, b, 0);
				ph = PH_SOF_QSEL;
			end
			PH_SOF_QSEL: begin
				push_rec(K_QSEL, 0, cnt, b, 0);
				cnt++;
				ph = cnt == tot ? PH_START : PH_SOF_ID;
			end
			PH_DQT_IDX: begin
				take_seg();
				if (b >= 4) abort_frame(E_QIDX);
				else begin
					curtbl = b[1:0]; cnt = 0;
					if (segrem == 0) abort_frame(E_OVERRUN); else ph = PH_DQT_ENT;
				end
			end
			PH_DQT_ENT: begin
				take_seg();
				push_rec(K_QENTRY, curtbl, cnt, b, 0);
				cnt++;
				if (cnt >= QUANT_ENTRIES) ph = segrem != 0 ? PH_DQT_IDX : PH_START;
				else if (segrem == 0) abort_frame(E_OVERRUN);
			end
			PH_DHT_IDX: begin
				take_seg();
				if (b[3:0] >= 2) abort_frame(E_HIDX);
				else begin
					isdc = (b[7:4] == 0); curtbl = b[1:0]; cnt = 0; hvt = 0;
					if (segrem == 0) abort_frame(E_OVERRUN); else ph = PH_DHT_CNT;
				end
			end
			PH_DHT_CNT: begin
				take_seg();
				push_rec(isdc ? K_DC_CNT : K_AC_CNT, curtbl, cnt, b, 0);
				s = hvt + b;
				hvt = s > 255 ? 8'd255 : s[7:0];
				cnt++;
				if (cnt >= 16) begin
					if ((isdc && hvt > DC_MAX_VALUES) || hvt > MAX_HUFF_VALUES)
						abort_frame(E_HBIG);
					else if (hvt == 0) ph = segrem != 0 ? PH_DHT_IDX : PH_START;
					else if (segrem == 0) abort_frame(E_OVERRUN);
					else begin cnt = 0; ph = PH_DHT_VAL; end
				end else if (segrem == 0) abort_frame(E_OVERRUN);
			end
			PH_DHT_VAL: begin
				take_seg();
				push_rec(isdc ? K_DC_VAL : K_AC_VAL, curtbl, cnt, b, 0);
				cnt++;
				if (cnt >= hvt) ph = segrem != 0 ? PH_DHT_IDX : PH_START;
				else if (segrem == 0) abort_frame(E_OVERRUN);
			end
			PH_DRI_HI: begin hib = b; ph = PH_DRI_LO; end
			PH_DRI_LO: begin push_rec(K_RESTART, 0, 0, {hib, b}, 0); ph = PH_START; end
			PH_SOS_NC: begin
				push_rec(K_SCAN_CNT, 0, 0, b, 0);
				tot = b; cnt = 0;
				ph = b != 0 ? PH_SOS_SEL : PH_SOS_SKIP;
			end
			PH_SOS_SEL: begin push_rec(K_SCAN_SEL, 0, cnt, b, 0); ph = PH_SOS_TBL; end
			PH_SOS_TBL: begin
				push_rec(K_SCAN_TBL, 0, cnt, b, 0);
				cnt++;
				if (cnt == tot) begin cnt = 0; ph = PH_SOS_SKIP; end
				else ph = PH_SOS_SEL;
			end
			PH_SOS_SKIP: begin
				cnt++;
				if (cnt >= 3) begin
					push_rec(K_HDR_DONE, 0, 0, 0, 0);
					scancnt = 0; ph = PH_SCAN;
				end
			end
			PH_SCAN: if (scancnt != 24'hFFFFFF) scancnt++;
			PH_SKIP: begin take_seg(); if (segrem == 0) ph = PH_START; end
			default: ph = PH_DEAD;
		endcase
		if (fin) begin
			if (ph == PH_SCAN) push_rec(K_SCAN_LEN, 0, 0, scancnt, 0);
			else if (ph != PH_DEAD) abort_frame(E_OVERRUN);
			clear_frame();
		end
		if (nres > 0) pending_recs[$].last = 1'b1;
	endfunction

	task automatic send_beat(logic [7:0] b, logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_byte(b, fin);
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++) send_beat(frame[i], i == frame.size() - 1);
		in_valid <= 1'b0;
		frame.delete();
		@(negedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [15:0] val);
		wait (pending_recs.size() == 0);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_WIDTH) exp_w = val; else exp_h = val;
	endtask

	// frame builders
	function automatic void add_sof(logic [15:0] h, logic [15:0] w, int nc);
		frame.push_back(M_FF); frame.push_back(M_SOF0);
		frame.push_back(0); frame.push_back(8'd17);
		frame.push_back(8); frame.push_back(h[15:8]); frame.push_back(h[7:0]);
		frame.push_back(w[15:8]); frame.push_back(w[7:0]); frame.push_back(nc);
		for (int i = 0; i < nc; i++) begin
			frame.push_back($urandom); frame.push_back($urandom); frame.push_back($urandom);
		end
	endfunction

	function automatic void add_dqt(int ntab, bit rnd);
		logic [15:0] len;
		len = 2 + 65 * ntab;
		frame.push_back(M_FF); frame.push_back(M_DQT);
		frame.push_back(len[15:8]); frame.push_back(len[7:0]);
		for (int t = 0; t < ntab; t++) begin
			frame.push_back(rnd ? $urandom_range(0, 3) : t);
			repeat (64) frame.push_back($urandom);
		end
	endfunction

	function automatic void add_dht(bit dc, int tid);
		int c[16];
		int sum, lim;
		logic [15:0] len;
		sum = 0;
		lim = dc ? 12 : 20;
		for (int i = 0; i < 16; i++) begin
			c[i] = (sum < lim) ? $urandom_range(0, 2) : 0;
			sum += c[i];
		end
		if (sum > lim) begin c[15] -= sum - lim; sum = lim; end
		len = 2 + 17 + sum;
		frame.push_back(M_FF); frame.push_back(M_DHT);
		frame.push_back(len[15:8]); frame.push_back(len[7:0]);
		frame.push_back({dc ? 4'h0 : 4'h1, 4'(tid)});
		for (int i = 0; i < 16; i++) frame.push_back(c[i]);
		repeat (sum) frame.push_back($urandom);
	endfunction

	function automatic void add_sos(int nc, int scan);
		frame.push_back(M_FF); frame.push_back(M_SOS);
		frame.push_back(0); frame.push_back(6 + 2 * nc); frame.push_back(nc);
		repeat (2 * nc) frame.push_back($urandom);
		repeat (3 + scan) frame.push_back($urandom);
	endfunction

	task automatic test_directed_markers();
		// SOI, fill, skipped APP segment, DRI, short length, missing-FF errors
		frame = '{8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'hE0, 8'h00, 8'h04, 8'hAA, 8'h55,
			8'hFF, 8'hDD, 8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h00, 8'h00};
		add_sos(0, 2);
		send_frame();
		frame = '{8'h00};
		send_frame();
		frame = '{8'hFF, 8'hD8, 8'h12, 8'hFF};
		send_frame();
	endtask

	task automatic test_size_errors();
		set_reg(CFG_WIDTH, 16'hFFFF);
		set_reg(CFG_HEIGHT, 16'd1);
		add_sof(16'd1, 16'hFFFF, 1); add_sos(1, 1); send_frame();
		add_sof(16'd2, 16'hFFFF, 1); send_frame();
		add_sof(16'd1, 16'hFFFE, 1); send_frame();
		set_reg(CFG_WIDTH, 16'd1);
		set_reg(CFG_HEIGHT, 16'hFFFF);
		add_sof(16'hFFFF, 16'd1, 0); add_sos(1, 0); send_frame();
	endtask

	task automatic test_table_errors();
		frame = '{8'hFF, 8'hDB, 8'h00, 8'h43, 8'h04}; send_frame();
		frame = '{8'hFF, 8'hDB, 8'h00, 8'h03, 8'h01}; send_frame();
		frame = '{8'hFF, 8'hC4, 8'h00, 8'h13, 8'h12}; send_frame();
		frame = '{8'hFF, 8'hC4, 8'h00, 8'h20, 8'h00, 8'hFF}; // dc too big
		repeat (15) frame.push_back(0);
		send_frame();
		frame = '{8'hFF, 8'hC4, 8'h01, 8'h00, 8'h10, 8'hA3}; // ac too big
		repeat (15) frame.push_back(0);
		send_frame();
		frame = '{8'hFF, 8'hC4, 8'h00, 8'h05, 8'h00, 8'h01, 8'h01}; send_frame();
		add_dqt(1, 0);
		frame[3] = 8'h10; // DQT ends inside its table
		send_frame();
		frame = '{8'hFF, 8'hC4, 8'h00, 8'h13, 8'h10};
		repeat (16) frame.push_back(0);
		frame.push_back(8'hFF); frame.push_back(8'hD8);
		send_frame();
	endtask

	task automatic test_random_frames(int n);
		logic [15:0] w, h;
		int nb;
		for (int f = 0; f < n; f++) begin
			if (f % 4 == 0) begin
				set_reg(CFG_WIDTH, $urandom_range(1, 65535));
				set_reg(CFG_HEIGHT, $urandom_range(0, 1) ? 16'd480 : $urandom_range(1, 65535));
			end
			frame = '{8'hFF, 8'hD8};
			if ($urandom_range(0, 9) == 0) frame.push_back(8'hFF);
			if ($urandom_range(0, 1)) add_dqt($urandom_range(1, 2), 1);
			if ($urandom_range(0, 1)) add_dht($urandom_range(0, 1), $urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0) begin
				frame.push_back(M_FF); frame.push_back(M_DRI);
				frame.push_back(0); frame.push_back(4);
				frame.push_back($urandom); frame.push_back($urandom);
			end
			w = $urandom_range(0, 7) == 0 ? $urandom : exp_w;
			h = $urandom_range(0, 7) == 0 ? $urandom : exp_h;
			add_sof(h, w, $urandom_range(1, 4));
			add_sos($urandom_range(0, 4), $urandom_range(0, 20));
			nb = $urandom_range(0, 9);
			if (nb == 0) frame[$urandom_range(0, frame.size() - 1)] = $urandom;
			else if (nb == 1) frame = frame[0:$urandom_range(0, frame.size() - 1)];
			send_frame();
		end
	endtask

	initial begin
		arst_n = 0; cfg_we = 0; cfg_index = CFG_WIDTH; cfg_data = 0;
		in_valid = 0; data_byte = 0; final_byte = 0; out_stall = 0;
		mismatches = 0; cycles = 0; burst_left = 0;
		exp_w = 16'd640; exp_h = 16'd480;
		clear_frame();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed_markers();
		test_size_errors();
		test_table_errors();
		set_reg(CFG_HEIGHT, 16'd480);
		test_random_frames(2);
		wait (pending_recs.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_recs.size() == 0)
			$display("tb_jpeg_header_marker_parser_top: done, clean");
		else
			$display("tb_jpeg_header_marker_parser_top: done, errors");
		$finish;
	end
endmodule
